/* rtl/core/ssrb_pkg.sv */
// Shared types and constants for the scaled sample ring buffer.
`default_nettype none

package ssrb_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int GAIN_W      = 8;
    localparam int LEVEL_W     = 10;
    localparam int PROD_W      = 24;
    localparam int DIV_CONST   = 255;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 8'd240;

    // Request kinds
    typedef enum logic {
        KIND_WRITE = 1'b0,
        KIND_READ  = 1'b1
    } t_kind;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_READ
    } t_state;

    typedef struct packed {
        logic                       kind;
        logic signed [SAMPLE_W-1:0] sample;
    } t_req;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] read_data;
        logic                       read_valid;
        logic                       dropped;
        logic [LEVEL_W-1:0]         level;
    } t_rsp;

    // Step enables from the sequencer to the scaler
    typedef struct packed {
        logic mul_en;
        logic div_en;
    } t_scale_ctl;

endpackage

`default_nettype wire

/* rtl/core/ssrb_store.sv */
// Sample memory: one write port, one read port with registered read data.
`default_nettype none

module ssrb_store #(
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [AW-1:0]                       i_waddr,
    input  wire logic signed [ssrb_pkg::SAMPLE_W-1:0] i_wdata,
    input  wire logic                                i_re,
    input  wire logic [AW-1:0]                       i_raddr,
    output logic signed [ssrb_pkg::SAMPLE_W-1:0]     o_rdata
);
    import ssrb_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/ssrb_scale.sv */
// Gain scaler: signed sample * gain / 255, truncated toward zero, in three steps.
`default_nettype none

module ssrb_scale (
    input  wire logic                                i_clk,
    input  wire ssrb_pkg::t_scale_ctl                i_ctl,
    input  wire logic signed [ssrb_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [ssrb_pkg::GAIN_W-1:0]         i_gain,
    output logic signed [ssrb_pkg::SAMPLE_W-1:0]     o_scaled
);
    import ssrb_pkg::*;

    logic signed [PROD_W:0]     mul_full;
    logic signed [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]          mag;
    logic [PROD_W-1:0]          est_sum;
    logic [SAMPLE_W-1:0]        q_est;
    logic [PROD_W-1:0]          rem_full;
    logic [SAMPLE_W-1:0]        r_qe;
    logic [9:0]                 r_rem;
    logic                       r_neg;
    logic [SAMPLE_W-1:0]        q_fix;

    // step 1: product, |p| < 2^23
    assign mul_full = i_sample * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= mul_full[PROD_W-1:0];
        end
    end

    // step 2: quotient estimate m/256 + m/2^16 + m/2^24, low by at most one
    always_comb begin
        mag      = r_prod[PROD_W-1] ? -r_prod : r_prod;
        est_sum  = mag + (mag >> 8) + (mag >> 16);
        q_est    = est_sum[PROD_W-1:8];
        rem_full = mag - (PROD_W'(q_est) << 8) + PROD_W'(q_est);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.div_en) begin
            r_qe  <= q_est;
            r_rem <= rem_full[9:0];
            r_neg <= r_prod[PROD_W-1];
        end
    end

    // step 3: one-step correction and sign restore
    always_comb begin
        q_fix    = r_qe + SAMPLE_W'(r_rem >= 10'(DIV_CONST));
        o_scaled = r_neg ? -$signed(q_fix) : $signed(q_fix);
    end

endmodule

`default_nettype wire

/* rtl/core/scaled_sample_ring_buffer_core.sv */
// Scaled sample ring buffer: top level with request sequencer and ring pointers.
//
// Takes one request when start is high and busy is low. A write request goes
// through multiply, quotient estimate, correction with memory write, then the
// result; a read request goes through memory read, then the result. These
// steps come from the three-step gain scaler and the registered read data of
// the sample memory. The result appears for exactly one cycle with
// o_result_valid high, in the same cycle busy drops, and must be taken then:
// there is no back-pressure on the result side. The ring holds DEPTH-1
// samples; a write into a full ring drops the oldest one. The gain register
// resets to 240 and should be written only while busy is low.
`default_nettype none

module scaled_sample_ring_buffer_core #(
    parameter int DEPTH = 1024
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire ssrb_pkg::t_req                i_req,
    input  wire logic                          i_cfg_we,
    input  wire logic [ssrb_pkg::GAIN_W-1:0]   i_cfg_wdata,
    output logic                               o_result_valid,
    output ssrb_pkg::t_rsp                     o_rsp
);
    import ssrb_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_state                     r_state, n_state;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [GAIN_W-1:0]          r_gain;
    logic [AW-1:0]              r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]              r_rd_ptr, n_rd_ptr;
    logic                       r_res_vld, n_res_vld;
    t_rsp                       r_rsp, n_rsp;

    logic                       accept;
    logic [AW-1:0]              level_now;
    logic [AW-1:0]              n_level;
    logic [31:0]                level_ext;
    logic                       full;
    logic                       empty;
    logic                       mem_we;
    logic                       mem_re;
    logic signed [SAMPLE_W-1:0] mem_rdata;
    logic signed [SAMPLE_W-1:0] scaled;
    t_scale_ctl                 scale_ctl;

    assign accept    = start && (r_state == ST_IDLE);
    assign busy      = (r_state != ST_IDLE);
    assign level_now = r_wr_ptr - r_rd_ptr;
    assign full      = (level_now == AW'(DEPTH - 1));
    assign empty     = (r_wr_ptr == r_rd_ptr);

    ssrb_scale u_scale (
        .i_clk    (i_clk),
        .i_ctl    (scale_ctl),
        .i_sample (r_sample),
        .i_gain   (r_gain),
        .o_scaled (scaled)
    );

    ssrb_store #(.DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (scaled),
        .i_re    (mem_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (mem_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_req.kind == KIND_READ) ? ST_READ : ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  n_state = ST_FIN;
            ST_FIN:  n_state = ST_IDLE;
            ST_READ: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs, pointer updates and result
    always_comb begin
        scale_ctl        = '0;
        mem_we           = 1'b0;
        mem_re           = accept && (i_req.kind == KIND_READ);
        n_wr_ptr         = r_wr_ptr;
        n_rd_ptr         = r_rd_ptr;
        n_level          = level_now;
        n_res_vld        = 1'b0;
        n_rsp            = r_rsp;
        case (r_state)
            ST_MUL: begin
                scale_ctl.mul_en = 1'b1;
            end
            ST_DIV: begin
                scale_ctl.div_en = 1'b1;
            end
            ST_FIN: begin
                // store scaled sample, drop oldest when full
                mem_we         = 1'b1;
                n_wr_ptr       = r_wr_ptr + AW'(1);
                n_rd_ptr       = full ? r_rd_ptr + AW'(1) : r_rd_ptr;
                n_level        = full ? level_now : level_now + AW'(1);
                n_res_vld      = 1'b1;
                n_rsp.read_data  = '0;
                n_rsp.read_valid = 1'b0;
                n_rsp.dropped    = full;
            end
            ST_READ: begin
                // pop if anything is held
                n_res_vld        = 1'b1;
                n_rsp.dropped    = 1'b0;
                if (!empty) begin
                    n_rd_ptr         = r_rd_ptr + AW'(1);
                    n_level          = level_now - AW'(1);
                    n_rsp.read_data  = mem_rdata;
                    n_rsp.read_valid = 1'b1;
                end else begin
                    n_rsp.read_data  = '0;
                    n_rsp.read_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
        level_ext   = 32'(n_level);
        n_rsp.level = level_ext[LEVEL_W-1:0];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_res_vld <= 1'b0;
            r_gain    <= GAIN_RESET;
        end else begin
            r_state   <= n_state;
            r_wr_ptr  <= n_wr_ptr;
            r_rd_ptr  <= n_rd_ptr;
            r_res_vld <= n_res_vld;
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
        end
    end

    // request capture and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_req.sample;
        end
        r_rsp <= n_rsp;
    end

    assign o_result_valid = r_res_vld;
    assign o_rsp          = r_rsp;

endmodule

`default_nettype wire

/* rtl/core/ssrb_checker.sv */
// Port-level checks for the scaled sample ring buffer, bound to the top level.
`default_nettype none

module ssrb_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        start,
    input wire logic                        busy,
    input wire logic                        o_result_valid,
    input wire ssrb_pkg::t_rsp              o_rsp
);
    import ssrb_pkg::*;

    // an accepted request always raises busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted request");

    // the result shows up exactly when the block frees up
    a_fall_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_result_valid)
        else $error("busy dropped without a result");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result while still busy");

    // a pop never reports a drop, and a non-pop returns zero data
    a_pop_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_rsp.read_valid |-> !o_rsp.dropped)
        else $error("read result flagged as drop");

    a_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_rsp.read_valid |-> o_rsp.read_data == '0)
        else $error("nonzero data without a popped sample");

endmodule

bind scaled_sample_ring_buffer_core ssrb_checker u_ssrb_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_rsp          (o_rsp)
);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the scaled sample ring buffer core.
`timescale 1ns / 100ps

module testbench;

    import ssrb_pkg::*;

    localparam int RING_DEPTH  = 1024;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYC  = 10;
    localparam int MAX_REPORTS = 10;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_req                 req_drv;
    logic                 i_cfg_we;
    logic [GAIN_W-1:0]    i_cfg_wdata;
    logic                 o_result_valid;
    t_rsp                 o_rsp;

    scaled_sample_ring_buffer_core #(
        .DEPTH (RING_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req          (req_drv),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_rsp          (o_rsp)
    );

    // Requests waiting to be driven, results predicted but not yet seen
    t_req pending_requests[$];
    t_rsp predicted_results[$];

    // Shadow copy of the ring and the gain register
    logic signed [SAMPLE_W-1:0] ring_store [RING_DEPTH];
    logic [PTR_W-1:0]           ring_wr_ptr;
    logic [PTR_W-1:0]           ring_rd_ptr;
    logic [GAIN_W-1:0]          ring_gain;

    logic req_taken;
    int   sender_idle_pct;
    int   error_count;
    int   mismatch_count;
    int   cycle_count;
    t_rsp want_rsp;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    function automatic logic [PTR_W-1:0] ring_fill();
        return ring_wr_ptr - ring_rd_ptr;
    endfunction

    // Apply one request to the shadow ring and return the result it yields
    function automatic t_rsp apply_request(t_req req);
        t_rsp                       rsp;
        int                         sample_int;
        int                         product;
        logic signed [SAMPLE_W-1:0] scaled;
        rsp = '0;
        if (req.kind == KIND_WRITE) begin
            sample_int = $signed(req.sample);
            if (ring_gain == GAIN_W'(DIV_CONST)) begin
                scaled = req.sample;
            end else begin
                // signed divide truncates toward zero
                product = sample_int * int'(ring_gain);
                scaled  = SAMPLE_W'(product / DIV_CONST);
            end
            // full ring: drop the oldest sample first
            if (ring_fill() == PTR_W'(RING_DEPTH - 1)) begin
                ring_rd_ptr = ring_rd_ptr + 1'b1;
                rsp.dropped = 1'b1;
            end
            ring_store[ring_wr_ptr] = scaled;
            ring_wr_ptr = ring_wr_ptr + 1'b1;
        end else if (ring_fill() != '0) begin
            rsp.read_data  = ring_store[ring_rd_ptr];
            rsp.read_valid = 1'b1;
            ring_rd_ptr    = ring_rd_ptr + 1'b1;
        end
        rsp.level = LEVEL_W'(ring_fill());
        return rsp;
    endfunction

    // Monitor: check results, predict accepted requests, track gain writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ring_wr_ptr = '0;
            ring_rd_ptr = '0;
            ring_gain   = GAIN_RESET;
            req_taken  <= 1'b0;
        end else begin
            if (o_result_valid) begin
                if (predicted_results.size() == 0) begin
                    error_count++;
                    if (mismatch_count < MAX_REPORTS)
                        $display("unexpected result: data=%0d valid=%0b drop=%0b level=%0d",
                                 o_rsp.read_data, o_rsp.read_valid, o_rsp.dropped,
                                 o_rsp.level);
                    mismatch_count++;
                end else begin
                    want_rsp = predicted_results.pop_front();
                    if (o_rsp.read_data !== want_rsp.read_data ||
                        o_rsp.read_valid !== want_rsp.read_valid ||
                        o_rsp.dropped !== want_rsp.dropped ||
                        o_rsp.level !== want_rsp.level) begin
                        error_count++;
                        if (mismatch_count < MAX_REPORTS) begin
                            $display("mismatch: expected data=%0d valid=%0b drop=%0b level=%0d",
                                     want_rsp.read_data, want_rsp.read_valid,
                                     want_rsp.dropped, want_rsp.level);
                            $display("          got      data=%0d valid=%0b drop=%0b level=%0d",
                                     o_rsp.read_data, o_rsp.read_valid,
                                     o_rsp.dropped, o_rsp.level);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy) begin
                predicted_results.push_back(apply_request(req_drv));
                req_taken <= 1'b1;
            end else begin
                req_taken <= 1'b0;
            end
            if (i_cfg_we)
                ring_gain = i_cfg_wdata;
        end
    end

    // Driver: hold a request until taken, then present the next or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !req_taken) begin
            start <= 1'b1;
        end else if (pending_requests.size() == 0 ||
                     $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
        end else begin
            start   <= 1'b1;
            req_drv <= pending_requests.pop_front();
        end
    end

    task automatic queue_request(logic kind, logic signed [SAMPLE_W-1:0] sample);
        t_req req;
        req.kind   = kind;
        req.sample = sample;
        pending_requests.push_back(req);
    endtask

    task automatic queue_random(int count, int write_pct);
        for (int i = 0; i < count; i++)
            queue_request(($urandom_range(99) < write_pct) ? KIND_WRITE : KIND_READ,
                          SAMPLE_W'($urandom));
    endtask

    // Sender pause: all requests taken and all results back
    task automatic wait_drained();
        while (pending_requests.size() != 0 || start || busy ||
               predicted_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_gain(logic [GAIN_W-1:0] gain);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= gain;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        error_count     = 0;
        mismatch_count  = 0;
        sender_idle_pct = 0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        req_drv         = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset gain, read on empty, sample extremes
        queue_request(KIND_READ, 16'sh7FFF);
        queue_request(KIND_WRITE, 16'sh7FFF);
        queue_request(KIND_WRITE, -16'sh8000);
        queue_request(KIND_WRITE, 16'sh0000);
        queue_request(KIND_WRITE, -16'sh0001);
        queue_request(KIND_WRITE, 16'sh0001);
        queue_request(KIND_WRITE, 16'sh00FF);
        repeat (7) queue_request(KIND_READ, SAMPLE_W'($urandom));

        // Passthrough gain
        write_gain(8'd255);
        queue_request(KIND_WRITE, 16'sh7FFF);
        queue_request(KIND_WRITE, -16'sh8000);
        queue_request(KIND_WRITE, -16'sh0001);
        repeat (3) queue_request(KIND_READ, -16'sh8000);

        // Zero gain
        write_gain(8'd0);
        queue_request(KIND_WRITE, 16'sh3039);
        queue_request(KIND_WRITE, -16'sh8000);
        repeat (2) queue_request(KIND_READ, 16'sh0000);

        // Random: smallest nonzero gain, mixed traffic, no idling
        write_gain(8'd1);
        sender_idle_pct = 0;
        queue_random(200, 50);

        // Zero gain with a sender idle about half the time
        write_gain(8'd0);
        sender_idle_pct = 49;
        queue_random(150, 50);

        // Passthrough, write heavy: fills the ring and overwrites the oldest
        write_gain(8'd255);
        sender_idle_pct = 0;
        queue_random(1100, 98);

        // Random gain, read heavy: the ring drains down from full
        write_gain(GAIN_W'($urandom));
        sender_idle_pct = 32;
        queue_random(250, 30);

        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (predicted_results.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
